>>> hdl/sbpr_pkg.sv
// ----------------------------------------------------------------------------
// Byte pattern replace: shared package
// Types and fixed sizes used by the window cells, the result queue and the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbpr_pkg;

   // Largest pattern or replacement, in bytes (one 64-bit register).
   localparam int BYTE_CAP  = 8;
   // Most results that one input transaction can produce.
   localparam int MAX_RES   = 8;
   localparam int RES_W     = 4;
   localparam int RES_IDX_W = 3;
   // Result queue holds two full bursts so input can continue while one waits.
   localparam int QDEPTH    = 16;
   localparam int QCNT_W    = 5;
   localparam int CSR_W     = 64;
   localparam int LEN_W     = 4;

   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic load;   // a byte is taken into the window this cycle
      logic shift;  // the window drops its oldest byte
   } cell_ctl_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last;
   } result_type;

endpackage

>>> hdl/sbpr_cell.sv
// ----------------------------------------------------------------------------
// Byte pattern replace: window cell
// Holds one window byte, compares it with its pattern byte and passes its
// byte to the neighbor below when the window shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbpr_cell
   import sbpr_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         wr_sel,
   input  logic [7:0]   in_byte,
   input  logic [7:0]   next_cand,
   input  logic [7:0]   pattern_byte,
   output logic [7:0]   cand,
   output logic         match
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // The incoming byte lands in the cell at the current fill position.
   assign cand  = wr_sel ? in_byte : byte_ff;
   assign match = (cand == pattern_byte);

   always_comb begin
      byte_in = byte_ff;
      if (ctl.load) begin
         byte_in = ctl.shift ? next_cand : cand;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

>>> hdl/sbpr_res_queue.sv
// ----------------------------------------------------------------------------
// Byte pattern replace: result queue
// A shifting row of result slots. A burst of up to eight results is written
// behind the occupied slots; the head slot drives the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbpr_res_queue
   import sbpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [RES_W-1:0]  push_count,
   input  result_type        push_items [MAX_RES],
   input  logic              pop,
   output result_type        head,
   output logic [QCNT_W-1:0] count
);

   result_type        slot_ff [QDEPTH];
   result_type        slot_in [QDEPTH];
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic [QCNT_W-1:0] base;
   logic [QCNT_W-1:0] offset [QDEPTH];

   assign base = count_ff - QCNT_W'(pop);

   always_comb begin
      for (int j = 0; j < QDEPTH; j++) begin
         offset[j]  = QCNT_W'(j) - base;
         slot_in[j] = pop ? slot_ff[(j + 1) % QDEPTH] : slot_ff[j];
         if (push && (QCNT_W'(j) >= base) && (offset[j] < QCNT_W'(push_count))) begin
            slot_in[j] = push_items[offset[j][RES_IDX_W-1:0]];
         end
      end
      count_in = base + (push ? QCNT_W'(push_count) : QCNT_W'(0));
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QDEPTH; j++) begin
         slot_ff[j] <= slot_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = slot_ff[0];
   assign count = count_ff;

endmodule

>>> hdl/stream_byte_pattern_replace_top.sv
// ----------------------------------------------------------------------------
// Streaming byte pattern replace: top level
// Results of a transaction are written into the result queue and reach rsp
// behind any results still queued. Throughput: one byte per cycle; each result
// takes its own turn on the result port, and req stalls while more than eight are queued.
// Reset clears the window, the result queue and the registers to their
// defaults (pattern length one, empty replacement).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_byte_pattern_replace_top
   import sbpr_pkg::*;
#(
   parameter int PATTERN_MAX = 8
) (
   input  logic             clock,
   input  logic             reset,
   // Input byte stream
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_stream,
   // Rewritten stream
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic             rsp_last,
   // Register write port
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   // The window never holds more bytes than the longest usable pattern.
   localparam int CELLS  = (PATTERN_MAX < BYTE_CAP) ? PATTERN_MAX : BYTE_CAP;
   localparam int FILL_W = $clog2(CELLS + 1);

   // Configuration registers.
   logic [63:0]      pattern_bytes_ff;
   logic [LEN_W-1:0] pattern_length_ff;
   logic [63:0]      replacement_bytes_ff;
   logic [LEN_W-1:0] replacement_length_ff;

   // Window state: the byte cells hold the data, fill_ff counts valid bytes.
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   logic [FILL_W-1:0] plen;
   logic [RES_W-1:0]  rlen;
   logic [FILL_W-1:0] wr_idx;
   logic              full;
   logic              hit;
   logic              accept;
   logic              pop;
   logic [CELLS-1:0]  match;
   logic [CELLS-1:0]  plen_mask;
   logic [7:0]        cand [CELLS];
   cell_ctl_type      cell_ctl;

   logic [RES_W-1:0]  res_count;
   logic              marker;
   logic [RES_W-1:0]  push_count;
   result_type        push_items [MAX_RES];
   result_type        head;
   logic [QCNT_W-1:0] q_count;

   // ------------------------------------------------------------------------
   // Register writes. Writing the pattern length also empties the window;
   // the fill counter handles that below.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= LEN_W'(1);
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:      pattern_bytes_ff      <= csr_wdata;
            CSR_PATTERN_LENGTH:     pattern_length_ff     <= csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_wdata;
            CSR_REPLACEMENT_LENGTH: replacement_length_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // A zero pattern length acts as one; longer values saturate at the cell
   // count. The replacement saturates at eight bytes.
   always_comb begin
      if (pattern_length_ff == '0) begin
         plen = FILL_W'(1);
      end else if (pattern_length_ff > LEN_W'(CELLS)) begin
         plen = FILL_W'(CELLS);
      end else begin
         plen = pattern_length_ff[FILL_W-1:0];
      end
      if (replacement_length_ff > LEN_W'(BYTE_CAP)) begin
         rlen = RES_W'(BYTE_CAP);
      end else begin
         rlen = replacement_length_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Window compare. The new byte is written at the fill position; when that
   // makes the window as long as the pattern, every cell within the pattern length compares at once.
   // ------------------------------------------------------------------------
   assign accept = req_valid & ~req_stall;
   assign wr_idx = (fill_ff >= plen) ? '0 : fill_ff;
   assign full   = ((wr_idx + FILL_W'(1)) == plen);

   always_comb begin
      for (int i = 0; i < CELLS; i++) begin
         plen_mask[i] = (FILL_W'(i) < plen);
      end
   end

   assign hit            = full & (&(match | ~plen_mask));
   assign cell_ctl.load  = accept;
   assign cell_ctl.shift = full & ~hit;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic [7:0] next_cand;

      if (i < CELLS - 1) begin : g_mid
         assign next_cand = cand[i + 1];
      end else begin : g_end
         assign next_cand = 8'h00;
      end

      sbpr_cell u_cell (
         .clock        (clock),
         .ctl          (cell_ctl),
         .wr_sel       (wr_idx == FILL_W'(i)),
         .in_byte      (req_data_byte),
         .next_cand    (next_cand),
         .pattern_byte (pattern_bytes_ff[8*i +: 8]),
         .cand         (cand[i]),
         .match        (match[i])
      );
   end

   // A pattern length write, a match or the end of the stream empties the window; a miss on a full
   // window drops the oldest byte, leaving the fill where it was.
   always_comb begin
      fill_in = fill_ff;
      if (csr_we && (csr_index_type'(csr_index) == CSR_PATTERN_LENGTH)) begin
         fill_in = '0;
      end else if (accept) begin
         if (req_end_of_stream || hit) begin
            fill_in = '0;
         end else if (full) begin
            fill_in = wr_idx;
         end else begin
            fill_in = wr_idx + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result burst. Without a match, results are simply the window bytes in
   // order: the oldest one on a full window, and all of them at the end of
   // the stream. With a match they are the replacement bytes.
   // ------------------------------------------------------------------------
   always_comb begin
      if (hit) begin
         res_count = rlen;
      end else if (full) begin
         res_count = req_end_of_stream ? RES_W'(plen) : RES_W'(1);
      end else begin
         res_count = req_end_of_stream ? (RES_W'(wr_idx) + RES_W'(1)) : '0;
      end
   end

   // An end of stream that produced nothing still sends one empty marker.
   assign marker     = req_end_of_stream & (res_count == '0);
   assign push_count = marker ? RES_W'(1) : res_count;

   for (genvar k = 0; k < MAX_RES; k++) begin : g_item
      logic [7:0] win_byte;

      if (k < CELLS) begin : g_win
         assign win_byte = cand[k];
      end else begin : g_none
         assign win_byte = 8'h00;
      end

      assign push_items[k].out_byte = marker ? 8'h00 :
                                      hit    ? replacement_bytes_ff[8*k +: 8] : win_byte;
      assign push_items[k].has_byte = ~marker;
      assign push_items[k].last     = req_end_of_stream &
                                      (RES_W'(k) == (push_count - RES_W'(1)));
   end

   // ------------------------------------------------------------------------
   // Result queue. Input is taken while at most eight results are queued, so
   // a full burst always fits behind a result that is still waiting.
   // ------------------------------------------------------------------------
   assign pop = rsp_valid & ~rsp_stall;

   sbpr_res_queue u_res_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_count (push_count),
      .push_items (push_items),
      .pop        (pop),
      .head       (head),
      .count      (q_count)
   );

   assign req_stall    = (q_count > QCNT_W'(MAX_RES));
   assign rsp_valid    = (q_count != '0);
   assign rsp_out_byte = head.out_byte;
   assign rsp_has_byte = head.has_byte;
   assign rsp_last     = head.last;

`ifndef NO_ASSERTIONS
   // The window never reaches the pattern length between transactions.
   a_fill_below_plen : assert property (@(posedge clock) disable iff (reset)
      fill_ff < plen)
      else $error("window fill reached the pattern length");

   // Every end-of-stream transaction leaves at least one queued result.
   a_eos_gives_result : assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_stream) |=> rsp_valid)
      else $error("end of stream produced no result");

   // A match with a nonempty replacement leaves at least one queued result.
   a_hit_gives_result : assert property (@(posedge clock) disable iff (reset)
      (accept && hit && (rlen != '0)) |=> rsp_valid)
      else $error("match with replacement produced no result");

   // The queue never overflows.
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QDEPTH))
      else $error("result queue overflow");
`endif

endmodule
